@@ sv/thread_slot_scheduler_core_defines.svh @@
// Assertion helpers shared by the scheduler RTL.
`ifndef THREAD_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define THREAD_SLOT_SCHEDULER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tss_pkg.sv @@
package tss_pkg;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_START   = 3'd1,
    REQ_CANCEL  = 3'd2,
    REQ_RELEASE = 3'd3,
    REQ_RESCHED = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_REFUSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SS_UNUSED   = 2'd0,
    SS_CREATED  = 2'd1,
    SS_RUNNABLE = 2'd2,
    SS_FINISHED = 2'd3
  } sstate_t;

  typedef enum logic [1:0] {
    Q_NONE  = 2'd0,
    Q_FREE  = 2'd1,
    Q_READY = 2'd2
  } qtag_t;

  // Per-field write enables of the slot record memory.
  typedef struct packed {
    logic st;
    logic rc;
    logic nx;
    logic pv;
    logic tag;
  } wr_en_t;

endpackage

@@ sv/tss_slot_mem.sv @@
module tss_slot_mem #(
  parameter int SLOT_COUNT = 32,
  parameter int IW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IW-1:0]   rd_addr,
  output logic [1:0]      rd_st,
  output logic [1:0]      rd_rc,
  output logic [IW-1:0]   rd_nx,
  output logic [IW-1:0]   rd_pv,
  output logic [1:0]      rd_tag,
  input  tss_pkg::wr_en_t wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  logic [1:0]      wr_st,
  input  logic [1:0]      wr_rc,
  input  logic [IW-1:0]   wr_nx,
  input  logic [IW-1:0]   wr_pv,
  input  logic [1:0]      wr_tag
);
  import tss_pkg::*;

  logic [1:0]    st_mem  [SLOT_COUNT];
  logic [1:0]    rc_mem  [SLOT_COUNT];
  logic [IW-1:0] nx_mem  [SLOT_COUNT];
  logic [IW-1:0] pv_mem  [SLOT_COUNT];
  logic [1:0]    tag_mem [SLOT_COUNT];

  // An entry whose field was never written reads as its reset value.
  logic [SLOT_COUNT-1:0] st_vld_r, rc_vld_r, nx_vld_r, pv_vld_r, tag_vld_r;

  logic [1:0]    st_q_r, rc_q_r, tag_q_r;
  logic [IW-1:0] nx_q_r, pv_q_r, addr_q_r;
  logic          st_v_r, rc_v_r, nx_v_r, pv_v_r, tag_v_r;

  always_ff @(posedge clk) begin
    if (wr_en.st)  st_mem[wr_addr]  <= wr_st;
    if (wr_en.rc)  rc_mem[wr_addr]  <= wr_rc;
    if (wr_en.nx)  nx_mem[wr_addr]  <= wr_nx;
    if (wr_en.pv)  pv_mem[wr_addr]  <= wr_pv;
    if (wr_en.tag) tag_mem[wr_addr] <= wr_tag;
    st_q_r   <= st_mem[rd_addr];
    rc_q_r   <= rc_mem[rd_addr];
    nx_q_r   <= nx_mem[rd_addr];
    pv_q_r   <= pv_mem[rd_addr];
    tag_q_r  <= tag_mem[rd_addr];
    addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      rc_vld_r  <= '0;
      nx_vld_r  <= '0;
      pv_vld_r  <= '0;
      tag_vld_r <= '0;
      st_v_r    <= 1'b0;
      rc_v_r    <= 1'b0;
      nx_v_r    <= 1'b0;
      pv_v_r    <= 1'b0;
      tag_v_r   <= 1'b0;
    end else begin
      if (wr_en.st)  st_vld_r[wr_addr]  <= 1'b1;
      if (wr_en.rc)  rc_vld_r[wr_addr]  <= 1'b1;
      if (wr_en.nx)  nx_vld_r[wr_addr]  <= 1'b1;
      if (wr_en.pv)  pv_vld_r[wr_addr]  <= 1'b1;
      if (wr_en.tag) tag_vld_r[wr_addr] <= 1'b1;
      st_v_r  <= st_vld_r[rd_addr];
      rc_v_r  <= rc_vld_r[rd_addr];
      nx_v_r  <= nx_vld_r[rd_addr];
      pv_v_r  <= pv_vld_r[rd_addr];
      tag_v_r <= tag_vld_r[rd_addr];
    end
  end

  logic [IW-1:0] nx_rst, pv_rst;
  logic [1:0]    tag_rst;

  always_comb begin
    nx_rst  = (addr_q_r == IW'(SLOT_COUNT - 1)) ? '0 : addr_q_r + IW'(1);
    pv_rst  = (addr_q_r == '0) ? '0 : addr_q_r - IW'(1);
    tag_rst = (addr_q_r == '0) ? Q_NONE : Q_FREE;
  end

  assign rd_st  = st_v_r  ? st_q_r  : SS_UNUSED;
  assign rd_rc  = rc_v_r  ? rc_q_r  : 2'd0;
  assign rd_nx  = nx_v_r  ? nx_q_r  : nx_rst;
  assign rd_pv  = pv_v_r  ? pv_q_r  : pv_rst;
  assign rd_tag = tag_v_r ? tag_q_r : tag_rst;

endmodule

@@ sv/thread_slot_scheduler_core.sv @@
// Sequencing: the result of a request loads once any earlier result is taken; a reschedule from main
// drops each finished slot found at the ready head, and frees it if that was its last reference.
// Throughput: one request at a time; the next is accepted the cycle after the result loads. The
// sequencer steps the slot record memory, one read and one write per cycle.
// Reset: synchronous, active low; all slots unused, slots 1 and up free, ready queue empty, slot 0 running.
`include "thread_slot_scheduler_core_defines.svh"

module thread_slot_scheduler_core #(
  parameter int SLOT_COUNT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [4:0] in_target_slot,
  input  logic       in_stack_granted,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [4:0] out_result_slot,
  output logic [1:0] out_slot_state,
  output logic [4:0] out_running_slot,
  output logic       out_switched
);
  import tss_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int HW = $clog2(SLOT_COUNT + 1);
  localparam logic [HW-1:0] NIL = HW'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RM_RD, S_RM_DEC, S_RM_PV, S_RM_NX, S_RM_S,
    S_AP_T, S_AP_S, S_RS_CHK, S_RS_DEC, S_RS_NM, S_RS_NM2,
    S_FIN, S_FIN_W, S_OUT
  } fsm_t;

  typedef enum logic {K_FIN, K_LOOP} cont_t;

  fsm_t state_r, state_nxt;
  cont_t cont_r, cont_nxt;
  logic [2:0] req_r, req_nxt;
  logic tgt_ok_r, tgt_ok_nxt, gr_r, gr_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt, cur_r, cur_nxt, before_r, before_nxt, s_r, s_nxt;
  logic [HW-1:0] rh_r, rh_nxt, rt_r, rt_nxt, fh_r, fh_nxt, ft_r, ft_nxt;
  logic pst_we_r, pst_we_nxt, prc_we_r, prc_we_nxt, ap_pend_r, ap_pend_nxt;
  logic [1:0] pst_r, pst_nxt, prc_r, prc_nxt, ap_tag_r, ap_tag_nxt;
  logic rm_q_r, rm_q_nxt, rm_head_r, rm_head_nxt, rm_tail_r, rm_tail_nxt;
  logic [IW-1:0] rm_nx_r, rm_nx_nxt, rm_pv_r, rm_pv_nxt;
  logic [1:0] status_r, status_nxt, sst_r, sst_nxt;
  logic [4:0] rslot_r, rslot_nxt;
  logic [IW-1:0] rep_r, rep_nxt;
  logic rep_ok_r, rep_ok_nxt;
  logic out_valid_r, out_valid_nxt, out_sw_r, out_sw_nxt;
  logic [1:0] out_status_r, out_status_nxt, out_sst_r, out_sst_nxt;
  logic [4:0] out_rslot_r, out_rslot_nxt, out_run_r, out_run_nxt;

  logic [IW-1:0] rd_addr, rd_nx, rd_pv, wr_addr, wr_nx, wr_pv;
  logic [1:0] rd_st, rd_rc, rd_tag, wr_st, wr_rc, wr_tag;
  wr_en_t wr_en;

  tss_slot_mem #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_mem (
    .clk, .rst_n, .rd_addr, .rd_st, .rd_rc, .rd_nx, .rd_pv, .rd_tag,
    .wr_en, .wr_addr, .wr_st, .wr_rc, .wr_nx, .wr_pv, .wr_tag
  );

  logic accept;
  logic ap_empty;
  logic [HW-1:0] ap_tail;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ap_tail  = (ap_tag_r == Q_FREE) ? ft_r : rt_r;
  assign ap_empty = (ap_tail >= NIL);

  always_comb begin
    state_nxt = state_r; cont_nxt = cont_r; req_nxt = req_r; tgt_ok_nxt = tgt_ok_r;
    gr_nxt = gr_r; tgt_nxt = tgt_r; cur_nxt = cur_r; before_nxt = before_r; s_nxt = s_r;
    rh_nxt = rh_r; rt_nxt = rt_r; fh_nxt = fh_r; ft_nxt = ft_r;
    pst_we_nxt = pst_we_r; pst_nxt = pst_r; prc_we_nxt = prc_we_r; prc_nxt = prc_r;
    ap_pend_nxt = ap_pend_r; ap_tag_nxt = ap_tag_r;
    rm_q_nxt = rm_q_r; rm_head_nxt = rm_head_r; rm_tail_nxt = rm_tail_r;
    rm_nx_nxt = rm_nx_r; rm_pv_nxt = rm_pv_r;
    status_nxt = status_r; sst_nxt = sst_r; rslot_nxt = rslot_r;
    rep_nxt = rep_r; rep_ok_nxt = rep_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r; out_sst_nxt = out_sst_r; out_rslot_nxt = out_rslot_r;
    out_run_nxt = out_run_r; out_sw_nxt = out_sw_r;
    rd_addr = s_r;
    wr_en = '0; wr_addr = s_r;
    wr_st = pst_r; wr_rc = prc_r; wr_nx = '0; wr_pv = '0; wr_tag = Q_NONE;

    case (state_r)
      S_IDLE: begin
        rd_addr = IW'(in_target_slot);
        if (accept) begin
          req_nxt    = in_req_type;
          tgt_nxt    = IW'(in_target_slot);
          tgt_ok_nxt = (32'(in_target_slot) < SLOT_COUNT);
          rep_nxt    = IW'(in_target_slot);
          rep_ok_nxt = (32'(in_target_slot) < SLOT_COUNT);
          gr_nxt     = in_stack_granted;
          before_nxt = cur_r;
          status_nxt = STS_OK;
          rslot_nxt  = '0;
          pst_we_nxt = 1'b0;
          prc_we_nxt = 1'b0;
          ap_pend_nxt = 1'b0;
          cont_nxt   = K_FIN;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        s_nxt = tgt_r;
        state_nxt = S_FIN;
        case (req_r)
          REQ_CREATE: begin
            if (cur_r != '0 || fh_r >= NIL || !gr_r) begin
              status_nxt = STS_REFUSED;
            end else begin
              s_nxt = fh_r[IW-1:0];
              rslot_nxt = 5'(fh_r[IW-1:0]);
              rep_nxt = fh_r[IW-1:0];
              rep_ok_nxt = 1'b1;
              pst_we_nxt = 1'b1; pst_nxt = SS_CREATED;
              prc_we_nxt = 1'b1; prc_nxt = 2'd1;
              state_nxt = S_RM_RD;
            end
          end
          REQ_START: begin
            if (!tgt_ok_r || rd_st != SS_CREATED) begin
              status_nxt = STS_INVALID;
            end else if (cur_r != '0) begin
              status_nxt = STS_REFUSED;
            end else begin
              pst_we_nxt = 1'b1; pst_nxt = SS_RUNNABLE;
              prc_we_nxt = 1'b1; prc_nxt = (rd_rc == 2'd3) ? 2'd3 : rd_rc + 2'd1;
              ap_pend_nxt = 1'b1; ap_tag_nxt = Q_READY;
              state_nxt = S_RM_RD;
            end
          end
          REQ_CANCEL: begin
            if (!tgt_ok_r || rd_st == SS_FINISHED || rd_st == SS_UNUSED) begin
              status_nxt = STS_INVALID;
            end else if (cur_r == '0) begin
              // Finish, dequeue and drop one reference in a single record update.
              pst_we_nxt = 1'b1; pst_nxt = (rd_rc == 2'd1) ? SS_UNUSED : SS_FINISHED;
              prc_we_nxt = (rd_rc != 2'd0);
              prc_nxt = (rd_rc == 2'd1) ? 2'd0 : rd_rc - 2'd1;
              ap_pend_nxt = (rd_rc == 2'd1); ap_tag_nxt = Q_FREE;
              state_nxt = S_RM_RD;
            end else begin
              wr_en.st = 1'b1; wr_addr = tgt_r; wr_st = SS_FINISHED;
              if (tgt_r == cur_r) begin
                cur_nxt = '0;
                if (rd_tag == Q_NONE) begin
                  ap_tag_nxt = Q_READY;
                  state_nxt = S_AP_T;
                end
              end
            end
          end
          REQ_RELEASE: begin
            if (!tgt_ok_r) begin
              status_nxt = STS_INVALID;
            end else if (cur_r != '0) begin
              status_nxt = STS_REFUSED;
            end else if (rd_rc == 2'd1) begin
              pst_we_nxt = 1'b1; pst_nxt = SS_UNUSED;
              prc_we_nxt = 1'b1; prc_nxt = 2'd0;
              ap_pend_nxt = 1'b1; ap_tag_nxt = Q_FREE;
              state_nxt = S_RM_RD;
            end else if (rd_rc != 2'd0) begin
              wr_en.rc = 1'b1; wr_addr = tgt_r; wr_rc = rd_rc - 2'd1;
            end
          end
          REQ_RESCHED: begin
            state_nxt = (cur_r == '0) ? S_RS_CHK : S_RS_NM;
          end
          default: begin
            status_nxt = STS_INVALID;
          end
        endcase
      end
      S_RM_RD: begin
        rd_addr = s_r;
        state_nxt = S_RM_DEC;
      end
      S_RM_DEC: begin
        rm_q_nxt = (rd_tag == Q_FREE) || (rd_tag == Q_READY);
        rm_nx_nxt = rd_nx;
        rm_pv_nxt = rd_pv;
        rm_head_nxt = 1'b0;
        rm_tail_nxt = 1'b0;
        if (rd_tag == Q_FREE) begin
          rm_head_nxt = (fh_r == HW'(s_r));
          rm_tail_nxt = (ft_r == HW'(s_r));
          if (fh_r == HW'(s_r)) fh_nxt = (ft_r == HW'(s_r)) ? NIL : HW'(rd_nx);
          if (ft_r == HW'(s_r)) ft_nxt = (fh_r == HW'(s_r)) ? NIL : HW'(rd_pv);
        end else if (rd_tag == Q_READY) begin
          rm_head_nxt = (rh_r == HW'(s_r));
          rm_tail_nxt = (rt_r == HW'(s_r));
          if (rh_r == HW'(s_r)) rh_nxt = (rt_r == HW'(s_r)) ? NIL : HW'(rd_nx);
          if (rt_r == HW'(s_r)) rt_nxt = (rh_r == HW'(s_r)) ? NIL : HW'(rd_pv);
        end
        state_nxt = S_RM_PV;
      end
      S_RM_PV: begin
        if (rm_q_r && !rm_head_r) begin
          wr_en.nx = 1'b1; wr_addr = rm_pv_r; wr_nx = rm_nx_r;
        end
        state_nxt = S_RM_NX;
      end
      S_RM_NX: begin
        if (rm_q_r && !rm_tail_r) begin
          wr_en.pv = 1'b1; wr_addr = rm_nx_r; wr_pv = rm_pv_r;
        end
        state_nxt = S_RM_S;
      end
      S_RM_S: begin
        wr_addr = s_r;
        wr_en.tag = 1'b1; wr_en.nx = 1'b1; wr_en.pv = 1'b1;
        wr_en.st = pst_we_r; wr_en.rc = prc_we_r;
        if (ap_pend_r) state_nxt = S_AP_T;
        else state_nxt = (cont_r == K_LOOP) ? S_RS_CHK : S_FIN;
      end
      S_AP_T: begin
        if (!ap_empty) begin
          wr_en.nx = 1'b1; wr_addr = ap_tail[IW-1:0]; wr_nx = s_r;
        end
        state_nxt = S_AP_S;
      end
      S_AP_S: begin
        wr_addr = s_r;
        wr_en.tag = 1'b1; wr_en.nx = 1'b1; wr_en.pv = 1'b1;
        wr_tag = ap_tag_r;
        wr_pv = ap_empty ? '0 : ap_tail[IW-1:0];
        if (ap_tag_r == Q_FREE) begin
          if (ap_empty) fh_nxt = HW'(s_r);
          ft_nxt = HW'(s_r);
        end else begin
          if (ap_empty) rh_nxt = HW'(s_r);
          rt_nxt = HW'(s_r);
        end
        state_nxt = (cont_r == K_LOOP) ? S_RS_CHK : S_FIN;
      end
      S_RS_CHK: begin
        rd_addr = rh_r[IW-1:0];
        state_nxt = (rh_r >= NIL) ? S_FIN : S_RS_DEC;
      end
      S_RS_DEC: begin
        s_nxt = rh_r[IW-1:0];
        if (rd_st == SS_FINISHED) begin
          pst_we_nxt = (rd_rc == 2'd1); pst_nxt = SS_UNUSED;
          prc_we_nxt = (rd_rc != 2'd0);
          prc_nxt = (rd_rc == 2'd1) ? 2'd0 : rd_rc - 2'd1;
          ap_pend_nxt = (rd_rc == 2'd1); ap_tag_nxt = Q_FREE;
          cont_nxt = K_LOOP;
        end else begin
          pst_we_nxt = 1'b0; prc_we_nxt = 1'b0; ap_pend_nxt = 1'b0;
          cur_nxt = rh_r[IW-1:0];
          cont_nxt = K_FIN;
        end
        state_nxt = S_RM_RD;
      end
      S_RS_NM: begin
        rd_addr = cur_r;
        state_nxt = S_RS_NM2;
      end
      S_RS_NM2: begin
        s_nxt = cur_r;
        cur_nxt = '0;
        ap_tag_nxt = Q_READY;
        state_nxt = (rd_tag == Q_NONE) ? S_AP_T : S_FIN;
      end
      S_FIN: begin
        rd_addr = rep_r;
        state_nxt = S_FIN_W;
      end
      S_FIN_W: begin
        sst_nxt = rep_ok_r ? rd_st : SS_UNUSED;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_rslot_nxt  = (req_r == REQ_RESCHED) ? 5'(cur_r) : rslot_r;
          out_sst_nxt    = sst_r;
          out_run_nxt    = 5'(cur_r);
          out_sw_nxt     = (cur_r != before_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cont_r <= K_FIN;
      cur_r <= '0;
      rh_r <= NIL;
      rt_r <= NIL;
      fh_r <= HW'(1);
      ft_r <= HW'(SLOT_COUNT - 1);
      out_valid_r <= 1'b0;
      pst_we_r <= 1'b0;
      prc_we_r <= 1'b0;
      ap_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cont_r <= cont_nxt;
      cur_r <= cur_nxt;
      rh_r <= rh_nxt;
      rt_r <= rt_nxt;
      fh_r <= fh_nxt;
      ft_r <= ft_nxt;
      out_valid_r <= out_valid_nxt;
      pst_we_r <= pst_we_nxt;
      prc_we_r <= prc_we_nxt;
      ap_pend_r <= ap_pend_nxt;
    end
    req_r <= req_nxt; tgt_ok_r <= tgt_ok_nxt; gr_r <= gr_nxt; tgt_r <= tgt_nxt;
    before_r <= before_nxt; s_r <= s_nxt;
    pst_r <= pst_nxt; prc_r <= prc_nxt; ap_tag_r <= ap_tag_nxt;
    rm_q_r <= rm_q_nxt; rm_head_r <= rm_head_nxt; rm_tail_r <= rm_tail_nxt;
    rm_nx_r <= rm_nx_nxt; rm_pv_r <= rm_pv_nxt;
    status_r <= status_nxt; sst_r <= sst_nxt; rslot_r <= rslot_nxt;
    rep_r <= rep_nxt; rep_ok_r <= rep_ok_nxt;
    out_status_r <= out_status_nxt; out_sst_r <= out_sst_nxt;
    out_rslot_r <= out_rslot_nxt; out_run_r <= out_run_nxt; out_sw_r <= out_sw_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_slot  = out_rslot_r;
  assign out_slot_state   = out_sst_r;
  assign out_running_slot = out_run_r;
  assign out_switched     = out_sw_r;

  `TSS_ASSERT_ALWAYS(a_ready_q_ends, (rh_r >= NIL) == (rt_r >= NIL), "ready queue ends disagree")
  `TSS_ASSERT_ALWAYS(a_free_q_ends, (fh_r >= NIL) == (ft_r >= NIL), "free queue ends disagree")
  `TSS_ASSERT_NEXT(a_accept_busy, accept, !in_ready && state_r == S_DEC, "busy after accept")

endmodule
